@@ hw/rtl/lse_pkg.sv @@
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types, codes and tables of the Lagrange shape function evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam logic [2:0] KIND_SEGMENT  = 3'd0;
	localparam logic [2:0] KIND_TRIANGLE = 3'd1;
	localparam logic [2:0] KIND_SQUARE   = 3'd2;
	localparam logic [2:0] KIND_TET      = 3'd3;
	localparam logic [2:0] KIND_CUBE     = 3'd4;

	localparam logic [1:0] ORDER_LINEAR    = 2'd1;
	localparam logic [1:0] ORDER_QUADRATIC = 2'd2;

	localparam logic signed [31:0] ONE28 = 32'sd268435456;
	localparam logic signed [21:0] ONE14 = 22'sd16384;

	// per node axis indices, packed as i0 + 4*i1 + 16*i2
	localparam logic [5:0] SQ_LIN  [4]  = '{6'd0, 6'd1, 6'd5, 6'd4};
	localparam logic [5:0] SQ_QUAD [9]  = '{6'd0, 6'd2, 6'd10, 6'd8, 6'd1, 6'd6, 6'd9, 6'd4,
		6'd5};
	localparam logic [5:0] CB_LIN  [8]  = '{6'd0, 6'd1, 6'd5, 6'd4, 6'd16, 6'd17, 6'd21,
		6'd20};
	localparam logic [5:0] CB_QUAD [27] = '{6'd0, 6'd2, 6'd10, 6'd8, 6'd32, 6'd34, 6'd42,
		6'd40, 6'd1, 6'd6, 6'd9, 6'd4, 6'd16, 6'd18, 6'd26, 6'd24, 6'd33, 6'd38, 6'd41,
		6'd36, 6'd5, 6'd17, 6'd22, 6'd25, 6'd20, 6'd37, 6'd21};

	typedef struct packed {
		logic                  bad;
		logic                  simplex;
		logic                  tet;
		logic                  quad;
		logic [1:0]            dims;
		logic [4:0]            count;
		logic signed [15:0]    x;
		logic signed [15:0]    y;
		logic signed [15:0]    z;
		logic [2:0][2:0][31:0] f;
		logic [2:0][2:0][31:0] d;
	} job_t;

	function automatic logic [5:0] node_axes(input logic [1:0] dims, input logic quad,
		input logic [4:0] n);
		logic [5:0] r;
		r = '0;
		if (dims == 2'd1) begin
			r = {4'd0, n[1:0]};
		end else if (dims == 2'd2) begin
			r = quad ? SQ_QUAD[n[3:0]] : SQ_LIN[n[1:0]];
		end else begin
			r = quad ? CB_QUAD[n] : CB_LIN[n[2:0]];
		end
		return r;
	endfunction

	function automatic logic [23:0] sat24(input logic signed [39:0] v);
		logic [23:0] r;
		if (v > 40'sd8388607) begin
			r = 24'h7FFFFF;
		end else if (v < -40'sd8388608) begin
			r = 24'h800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/lagrange_shape_eval.sv @@
// ----------------------------------------------------------------------------
// lagrange_shape_eval
// Lagrange shape values and gradients of order 1 and 2 on five element kinds.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  ---------+-----------------+-----------------------------------------------
//  item in  | start, busy     | element_kind, poly_order, coord_x/y/z
//  result   | valid (1 cycle) | node_index, shape_value, grad_x/y/z,
//           |                 | last_node, bad_request
//
// One result per cycle; an item occupies the node walker for its node count (1 to 27).
// An item passes the front register, job queue, stages 1 and 2 and output register.
// busy rises only when the front register and the two-entry job queue are full.
// Reset empties front, queue and pipe; results are never held off.
// ----------------------------------------------------------------------------
module lagrange_shape_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         element_kind,
	input  logic [1:0]         poly_order,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	output logic               valid,
	output logic [4:0]         node_index,
	output logic signed [23:0] shape_value,
	output logic signed [23:0] grad_x,
	output logic signed [23:0] grad_y,
	output logic signed [23:0] grad_z,
	output logic               last_node,
	output logic               bad_request
);

	lse_pkg::job_t job, head;
	logic          push, pop, empty, full;

	lse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_kind (element_kind),
		.poly_order   (poly_order),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.q_full       (full),
		.push         (push),
		.job          (job)
	);

	lse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	lse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.valid       (valid),
		.node_index  (node_index),
		.shape_value (shape_value),
		.grad_x      (grad_x),
		.grad_y      (grad_y),
		.grad_z      (grad_z),
		.last_node   (last_node),
		.bad_request (bad_request)
	);

endmodule

@@ hw/rtl/lse_front.sv @@
// ----------------------------------------------------------------------------
// lse_front
// Takes items, classifies kind and order, forms the per-axis factors.
// ----------------------------------------------------------------------------
module lse_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         element_kind,
	input  logic [1:0]         poly_order,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	input  logic               q_full,
	output logic               push,
	output lse_pkg::job_t      job
);

	logic               v_s1;
	logic [2:0]         kind_s1;
	logic [1:0]         order_s1;
	logic signed [15:0] cx_s1, cy_s1, cz_s1;
	logic               accept;

	assign busy   = v_s1 && q_full;
	assign accept = start && !busy;
	assign push   = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= element_kind;
			order_s1 <= poly_order;
			cx_s1    <= coord_x;
			cy_s1    <= coord_y;
			cz_s1    <= coord_z;
		end
	end

	always_comb begin
		logic signed [15:0] c;
		logic signed [39:0] c2, ck, ce;
		logic [1:0]         used;
		job = '0;
		job.bad = (order_s1 != lse_pkg::ORDER_LINEAR && order_s1 != lse_pkg::ORDER_QUADRATIC)
			|| (kind_s1 > lse_pkg::KIND_CUBE);
		job.quad = (order_s1 == lse_pkg::ORDER_QUADRATIC);
		job.x = cx_s1;
		job.y = cy_s1;
		job.z = cz_s1;
		used = 2'd1;
		unique case (kind_s1)
			lse_pkg::KIND_SEGMENT: begin
				used = 2'd1;
				job.count = job.quad ? 5'd3 : 5'd2;
			end
			lse_pkg::KIND_TRIANGLE: begin
				used = 2'd2;
				job.simplex = 1'b1;
				job.count = job.quad ? 5'd6 : 5'd3;
			end
			lse_pkg::KIND_SQUARE: begin
				used = 2'd2;
				job.count = job.quad ? 5'd9 : 5'd4;
			end
			lse_pkg::KIND_TET: begin
				used = 2'd3;
				job.simplex = 1'b1;
				job.tet = 1'b1;
				job.count = job.quad ? 5'd10 : 5'd4;
			end
			default: begin
				used = 2'd3;
				job.count = job.quad ? 5'd27 : 5'd8;
			end
		endcase
		job.dims = used;
		if (job.bad) begin
			job.count = 5'd1;
		end
		for (int a = 0; a < 3; a++) begin
			c  = (a == 0) ? cx_s1 : (a == 1) ? cy_s1 : cz_s1;
			ce = 40'(c);
			c2 = ce * ce;
			ck = ce <<< 14;
			if (a >= int'(used)) begin
				job.f[a][0] = lse_pkg::ONE28;
			end else if (!job.quad) begin
				job.f[a][0] = 32'((40'sd16384 - ce) <<< 13);
				job.f[a][1] = 32'((40'sd16384 + ce) <<< 13);
				job.d[a][0] = 32'(-40'sd134217728);
				job.d[a][1] = 32'(40'sd134217728);
			end else begin
				job.f[a][0] = 32'((c2 - ck) >>> 1);
				job.f[a][1] = 32'(40'sd268435456 - c2);
				job.f[a][2] = 32'((c2 + ck) >>> 1);
				job.d[a][0] = 32'((ce - 40'sd8192) <<< 14);
				job.d[a][1] = 32'(-(ce <<< 15));
				job.d[a][2] = 32'((ce + 40'sd8192) <<< 14);
			end
		end
	end

endmodule

@@ hw/rtl/lse_queue.sv @@
// ----------------------------------------------------------------------------
// lse_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module lse_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lse_pkg::job_t din,
	input  logic          pop,
	output lse_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	lse_pkg::job_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

@@ hw/rtl/lse_back.sv @@
// ----------------------------------------------------------------------------
// lse_back
// Walks the nodes of the head job, one per cycle, through a 3-stage product pipe.
// ----------------------------------------------------------------------------
module lse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lse_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          valid,
	output logic [4:0]    node_index,
	output logic [23:0]   shape_value,
	output logic [23:0]   grad_x,
	output logic [23:0]   grad_y,
	output logic [23:0]   grad_z,
	output logic          last_node,
	output logic          bad_request
);

	typedef struct packed {
		logic       simplex;
		logic       bad;
		logic       last;
		logic [4:0] node;
	} meta_t;

	logic [4:0] n_q;
	logic       issue;

	assign issue = !empty;
	assign pop   = issue && (n_q == head.count - 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 5'd0;
		end else if (pop) begin
			n_q <= 5'd0;
		end else if (issue) begin
			n_q <= n_q + 5'd1;
		end
	end

	// stage 0: operand selection
	logic signed [31:0] oa [4], ob [4], oc [4];
	logic signed [21:0] sp, sq;
	logic signed [23:0] sg [3];
	meta_t              m0;

	always_comb begin
		logic [5:0]         ix;
		logic [1:0]         i0, i1, i2;
		logic signed [21:0] X, Y, Z, S, L;
		logic [4:0]         m;
		ix = lse_pkg::node_axes(head.dims, head.quad, n_q);
		i0 = ix[1:0];
		i1 = ix[3:2];
		i2 = ix[5:4];
		oa[0] = head.f[0][i0]; ob[0] = head.f[1][i1]; oc[0] = head.f[2][i2];
		oa[1] = head.d[0][i0]; ob[1] = head.f[1][i1]; oc[1] = head.f[2][i2];
		oa[2] = head.f[0][i0]; ob[2] = head.d[1][i1]; oc[2] = head.f[2][i2];
		oa[3] = head.f[0][i0]; ob[3] = head.f[1][i1]; oc[3] = head.d[2][i2];

		X = 22'(head.x);
		Y = 22'(head.y);
		Z = head.tet ? 22'(head.z) : 22'sd0;
		S = X + Y + Z;
		L = lse_pkg::ONE14 - S;
		m = (!head.tet && n_q >= 5'd3) ? n_q + 5'd1 : n_q;
		sp = '0;
		sq = lse_pkg::ONE14;
		sg[0] = '0; sg[1] = '0; sg[2] = '0;
		if (!head.quad) begin
			case (n_q)
				5'd0: begin
					sp = L;
					sg[0] = -24'sd16384; sg[1] = -24'sd16384; sg[2] = -24'sd16384;
				end
				5'd1: begin sp = X; sg[0] = 24'sd16384; end
				5'd2: begin sp = Y; sg[1] = 24'sd16384; end
				default: begin sp = Z; sg[2] = 24'sd16384; end
			endcase
		end else begin
			case (m)
				5'd0: begin
					sp = L; sq = lse_pkg::ONE14 - (S <<< 1);
					sg[0] = 24'((S <<< 2) - 22'sd49152); sg[1] = sg[0]; sg[2] = sg[0];
				end
				5'd1: begin
					sp = X; sq = (X <<< 1) - lse_pkg::ONE14;
					sg[0] = 24'((X <<< 2) - lse_pkg::ONE14);
				end
				5'd2: begin
					sp = Y; sq = (Y <<< 1) - lse_pkg::ONE14;
					sg[1] = 24'((Y <<< 2) - lse_pkg::ONE14);
				end
				5'd3: begin
					sp = Z; sq = (Z <<< 1) - lse_pkg::ONE14;
					sg[2] = 24'((Z <<< 2) - lse_pkg::ONE14);
				end
				5'd4: begin
					sp = X <<< 2; sq = L;
					sg[0] = 24'(22'sd65536 - (X <<< 3) - (Y <<< 2) - (Z <<< 2));
					sg[1] = -24'(X <<< 2); sg[2] = sg[1];
				end
				5'd5: begin
					sp = Y <<< 2; sq = L;
					sg[0] = -24'(Y <<< 2); sg[2] = sg[0];
					sg[1] = 24'(22'sd65536 - (X <<< 2) - (Y <<< 3) - (Z <<< 2));
				end
				5'd6: begin
					sp = X <<< 2; sq = Y;
					sg[0] = 24'(Y <<< 2); sg[1] = 24'(X <<< 2);
				end
				5'd7: begin
					sp = Z <<< 2; sq = L;
					sg[0] = -24'(Z <<< 2); sg[1] = sg[0];
					sg[2] = 24'(22'sd65536 - (X <<< 2) - (Y <<< 2) - (Z <<< 3));
				end
				5'd8: begin
					sp = X <<< 2; sq = Z;
					sg[0] = 24'(Z <<< 2); sg[2] = 24'(X <<< 2);
				end
				default: begin
					sp = Y <<< 2; sq = Z;
					sg[1] = 24'(Z <<< 2); sg[2] = 24'(Y <<< 2);
				end
			endcase
		end
		if (!head.tet) begin
			sg[2] = '0;
		end
		m0.simplex = head.simplex;
		m0.bad     = head.bad;
		m0.last    = pop;
		m0.node    = n_q;
	end

	// stage 1: first products
	logic               v_s1;
	meta_t              m_s1;
	logic signed [63:0] ab_s1 [4];
	logic signed [31:0] c_s1 [4];
	logic signed [43:0] pq_s1;
	logic signed [23:0] g_s1 [3];

	// stage 2: second products
	logic               v_s2;
	meta_t              m_s2;
	logic signed [67:0] abc_s2 [4];
	logic signed [31:0] sv_s2;
	logic signed [23:0] g_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			valid <= 1'b0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_s1  <= m0;
		pq_s1 <= 44'(sp) * 44'(sq);
		for (int k = 0; k < 4; k++) begin
			ab_s1[k] <= 64'(oa[k]) * 64'(ob[k]);
			c_s1[k]  <= oc[k];
		end
		for (int k = 0; k < 3; k++) begin
			g_s1[k] <= sg[k];
		end

		m_s2  <= m_s1;
		sv_s2 <= 32'(pq_s1 >>> 12);
		for (int k = 0; k < 4; k++) begin
			abc_s2[k] <= 68'(36'(ab_s1[k] >>> 28)) * 68'(c_s1[k]);
		end
		for (int k = 0; k < 3; k++) begin
			g_s2[k] <= g_s1[k];
		end

		node_index  <= m_s2.node;
		last_node   <= m_s2.last;
		bad_request <= m_s2.bad;
		if (m_s2.bad) begin
			shape_value <= '0;
			grad_x      <= '0;
			grad_y      <= '0;
			grad_z      <= '0;
		end else if (m_s2.simplex) begin
			shape_value <= lse_pkg::sat24(40'(sv_s2));
			grad_x      <= lse_pkg::sat24(40'(g_s2[0]) <<< 2);
			grad_y      <= lse_pkg::sat24(40'(g_s2[1]) <<< 2);
			grad_z      <= lse_pkg::sat24(40'(g_s2[2]) <<< 2);
		end else begin
			shape_value <= lse_pkg::sat24(40'(abc_s2[0] >>> 40));
			grad_x      <= lse_pkg::sat24(40'(abc_s2[1] >>> 40));
			grad_y      <= lse_pkg::sat24(40'(abc_s2[2] >>> 40));
			grad_z      <= lse_pkg::sat24(40'(abc_s2[3] >>> 40));
		end
	end

endmodule
